>>> hw/rtl/kei_pkg.sv
// Shared types and codes for the keyframe eased interpolator.
package kei_pkg;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    EASE_LINEAR = 2'd0,
    EASE_IN     = 2'd1,
    EASE_OUT    = 2'd2,
    EASE_IN_OUT = 2'd3
  } ease_t;

  typedef struct packed {
    logic [31:0] ticks;
    logic [15:0] focus;
    logic [15:0] iris;
    logic [15:0] zoom;
    logic [1:0]  easing;
  } key_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CHK,
    S_INS_CMP,
    S_Q_FIRST,
    S_Q_LAST,
    S_Q_SCAN,
    S_DIV,
    S_EASE_MUL,
    S_EASE_FIN,
    S_BL_MUL,
    S_BL_FIN
  } state_t;

endpackage

>>> hw/rtl/kei_if.sv
// Request and response channel interfaces.
interface kei_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] time_ticks;
  logic [15:0] kf_focus;
  logic [15:0] kf_iris;
  logic [15:0] kf_zoom;
  logic [1:0]  kf_easing;

  modport source (output valid, req_type, time_ticks, kf_focus, kf_iris, kf_zoom, kf_easing,
                  input ready);
  modport sink (input valid, req_type, time_ticks, kf_focus, kf_iris, kf_zoom, kf_easing,
                output ready);
endinterface

interface kei_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] focus_out;
  logic [15:0] iris_out;
  logic [15:0] zoom_out;
  logic        status;
  logic [6:0]  count_out;

  modport source (output valid, focus_out, iris_out, zoom_out, status, count_out,
                  input ready);
  modport sink (input valid, focus_out, iris_out, zoom_out, status, count_out,
                output ready);
endinterface

>>> hw/rtl/keyframe_eased_interpolator.sv
// Keyframe table with eased interpolation. Words are taken one at a time. An insert moves
// each key with a later time up one slot, each move a read and a write on the table; when
// the table is full the key is rejected. A query that lands between two keys scans the keys
// one per cycle up to and including the later key of the bracketing pair, then runs the
// bit-serial divide for FRAC_BITS fraction bits, then the easing and three channel blends
// on one shared multiplier (linear easing needs no easing product).
// A new word is accepted once the previous response has been taken.
module keyframe_eased_interpolator import kei_pkg::*; #(
  parameter int MAX_KEYS  = 64,
  parameter int FRAC_BITS = 16
) (
  input logic    clk,
  input logic    rst,
  kei_req_if.sink   req,
  kei_rsp_if.source rsp
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int BW = $clog2(FRAC_BITS + 1);
  localparam int MW = (FRAC_BITS + 3 > 16) ? FRAC_BITS + 3 : 16;
  localparam int PW = 2 * MW;
  localparam logic [MW-1:0] ONE_M   = MW'(1) << FRAC_BITS;
  localparam logic [PW:0]   ROUND_M = (PW + 1)'((PW + 1)'(1) << FRAC_BITS) - (PW + 1)'(1);

  state_t state, state_next;

  logic [CW-1:0]        count;
  logic [CW-1:0]        idx;
  logic [31:0]          qtime;
  key_t                 nkey;
  key_t                 prev;
  key_t                 kb;
  logic [31:0]          rem;
  logic [31:0]          span;
  logic [FRAC_BITS-1:0] alpha;
  logic [FRAC_BITS-1:0] ease;
  logic [BW-1:0]        bitcnt;
  ease_t                mode;
  logic [1:0]           ch;
  logic                 out_valid;
  logic [15:0]          focus_r, iris_r, zoom_r;
  logic                 status_r;

  logic                 accept;
  logic                 finish;
  logic [CW-1:0]        ra_full;
  logic [CW-1:0]        wa_full;
  logic                 wr_en;
  key_t                 wr_data;
  key_t                 rd_data;
  logic [MW-1:0]        op_a, op_b;
  logic [PW-1:0]        prod;

  logic [32:0]          rem2;
  logic                 ge;
  logic [15:0]          lo, hi, diff, blend_val;
  logic [PW:0]          down_sum;
  logic [CW+6:0]        count_ext;

  kei_key_mem #(.DEPTH(MAX_KEYS), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wa_full[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (ra_full[AW-1:0]),
    .rd_data (rd_data)
  );

  kei_mul #(.MW(MW)) u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && !out_valid;

  assign rem2 = {rem, 1'b0};
  assign ge   = rem2 >= {1'b0, span};

  always_comb begin
    case (ch)
      2'd0:    begin lo = prev.focus; hi = kb.focus; end
      2'd1:    begin lo = prev.iris;  hi = kb.iris;  end
      default: begin lo = prev.zoom;  hi = kb.zoom;  end
    endcase
  end

  assign diff     = (hi >= lo) ? (hi - lo) : (lo - hi);
  assign down_sum = {1'b0, prod} + ROUND_M;
  assign blend_val = (hi >= lo) ? (lo + prod[FRAC_BITS+15:FRAC_BITS])
                                : (lo - down_sum[FRAC_BITS+15:FRAC_BITS]);

  always_comb begin
    state_next = state;
    finish     = 1'b0;
    ra_full    = '0;
    wa_full    = idx;
    wr_en      = 1'b0;
    wr_data    = nkey;
    op_a       = MW'(ease);
    op_b       = MW'(diff);
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_t'(req.req_type))
            REQ_INSERT: begin
              if (count >= CW'(MAX_KEYS)) finish = 1'b1;
              else state_next = S_INS_CHK;
            end
            REQ_QUERY: begin
              if (count == '0) finish = 1'b1;
              else state_next = S_Q_FIRST;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      S_INS_CHK: begin
        if (idx == '0) begin
          wr_en  = 1'b1;
          finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          ra_full = idx - CW'(1);
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        wr_en = 1'b1;
        if (rd_data.ticks > nkey.ticks) begin
          // move the later key up one slot
          wr_data = rd_data;
          state_next = S_INS_CHK;
        end else begin
          finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_Q_FIRST: begin
        if (count == CW'(1) || qtime <= rd_data.ticks) begin
          finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          ra_full = count - CW'(1);
          state_next = S_Q_LAST;
        end
      end
      S_Q_LAST: begin
        if (qtime >= rd_data.ticks) begin
          finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          ra_full = idx;
          state_next = S_Q_SCAN;
        end
      end
      S_Q_SCAN: begin
        if (rd_data.ticks > qtime) begin
          state_next = S_DIV;
        end else begin
          ra_full = idx + CW'(1);
        end
      end
      S_DIV: begin
        if (bitcnt == BW'(FRAC_BITS - 1)) state_next = S_EASE_MUL;
      end
      S_EASE_MUL: begin
        case (mode)
          EASE_IN: begin
            op_a = MW'(alpha);
            op_b = MW'(alpha);
          end
          EASE_OUT: begin
            op_a = MW'(alpha);
            op_b = (ONE_M << 1) - MW'(alpha);
          end
          EASE_IN_OUT: begin
            op_a = MW'(alpha);
            if (!alpha[FRAC_BITS-1]) op_b = MW'(alpha) << 1;
            else op_b = (ONE_M << 2) - (MW'(alpha) << 1);
          end
          default: begin
            op_a = MW'(alpha);
            op_b = MW'(1);
          end
        endcase
        state_next = (mode == EASE_LINEAR) ? S_BL_MUL : S_EASE_FIN;
      end
      S_EASE_FIN: state_next = S_BL_MUL;
      S_BL_MUL:   state_next = S_BL_FIN;
      S_BL_FIN: begin
        if (ch == 2'd2) begin
          finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_BL_MUL;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      if (finish) out_valid <= 1'b1;
      if (accept && req_t'(req.req_type) == REQ_CLEAR) count <= '0;
      if (finish && wr_en) count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          qtime       <= req.time_ticks;
          nkey.ticks  <= req.time_ticks;
          nkey.focus  <= req.kf_focus;
          nkey.iris   <= req.kf_iris;
          nkey.zoom   <= req.kf_zoom;
          nkey.easing <= req.kf_easing;
          idx         <= count;
          focus_r     <= '0;
          iris_r      <= '0;
          zoom_r      <= '0;
          status_r    <= (req_t'(req.req_type) == REQ_INSERT) && (count >= CW'(MAX_KEYS));
        end
      end
      S_INS_CMP: begin
        if (rd_data.ticks > nkey.ticks) idx <= idx - CW'(1);
      end
      S_Q_FIRST: begin
        prev    <= rd_data;
        idx     <= CW'(1);
        focus_r <= rd_data.focus;
        iris_r  <= rd_data.iris;
        zoom_r  <= rd_data.zoom;
      end
      S_Q_LAST: begin
        focus_r <= rd_data.focus;
        iris_r  <= rd_data.iris;
        zoom_r  <= rd_data.zoom;
      end
      S_Q_SCAN: begin
        if (rd_data.ticks > qtime) begin
          kb     <= rd_data;
          rem    <= qtime - prev.ticks;
          span   <= rd_data.ticks - prev.ticks;
          bitcnt <= '0;
          alpha  <= '0;
          mode   <= ease_t'(prev.easing);
        end else begin
          prev <= rd_data;
          idx  <= idx + CW'(1);
        end
      end
      S_DIV: begin
        rem    <= ge ? 32'(rem2 - {1'b0, span}) : rem2[31:0];
        alpha  <= {alpha[FRAC_BITS-2:0], ge};
        bitcnt <= bitcnt + BW'(1);
      end
      S_EASE_MUL: begin
        ease <= alpha;
        ch   <= 2'd0;
      end
      S_EASE_FIN: begin
        // the in-out upper branch subtracts one, which falls off above the fraction
        ease <= prod[2*FRAC_BITS-1:FRAC_BITS];
      end
      S_BL_FIN: begin
        case (ch)
          2'd0:    focus_r <= blend_val;
          2'd1:    iris_r  <= blend_val;
          default: zoom_r  <= blend_val;
        endcase
        ch <= ch + 2'd1;
      end
      default: ;
    endcase
  end

  assign count_ext     = {7'd0, count};
  assign rsp.valid     = out_valid;
  assign rsp.focus_out = focus_r;
  assign rsp.iris_out  = iris_r;
  assign rsp.zoom_out  = zoom_r;
  assign rsp.status    = status_r;
  assign rsp.count_out = count_ext[6:0];

endmodule

>>> hw/rtl/kei_key_mem.sv
// Keyframe table storage: one write port, one registered read port.
module kei_key_mem import kei_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  key_t          wr_data,
  input  logic [AW-1:0] rd_addr,
  output key_t          rd_data
);

  key_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/kei_mul.sv
// Shared unsigned multiplier with registered product.
module kei_mul #(
  parameter int MW = 19
) (
  input  logic            clk,
  input  logic [MW-1:0]   op_a,
  input  logic [MW-1:0]   op_b,
  output logic [2*MW-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

>>> tb/keyframe_eased_interpolator_tb.sv
// Self-checking testbench for the keyframe eased interpolator: directed and random traffic.
module keyframe_eased_interpolator_tb;
  import kei_pkg::*;

  localparam int MAX_KEYS  = 64;
  localparam int FRAC_BITS = 16;
  localparam longint unsigned ONE = 64'd1 << FRAC_BITS;

  typedef struct {
    logic [15:0] focus;
    logic [15:0] iris;
    logic [15:0] zoom;
    logic        status;
    logic [6:0]  count;
  } lens_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kei_req_if req ();
  kei_rsp_if rsp ();

  keyframe_eased_interpolator #(.MAX_KEYS(MAX_KEYS), .FRAC_BITS(FRAC_BITS)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always #10 clk = ~clk;

  // shadow keyframe table
  logic [31:0] tbl_time [MAX_KEYS];
  logic [15:0] tbl_focus [MAX_KEYS];
  logic [15:0] tbl_iris [MAX_KEYS];
  logic [15:0] tbl_zoom [MAX_KEYS];
  ease_t       tbl_ease [MAX_KEYS];
  int          tbl_count = 0;

  lens_result_t pending_results[$];
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int words_sent     = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int queries_sent   = 0;
  int rejects_seen   = 0;

  function automatic longint unsigned eased_alpha(longint unsigned a, ease_t mode);
    case (mode)
      EASE_IN:  return (a * a) >> FRAC_BITS;
      EASE_OUT: return (a * (2 * ONE - a)) >> FRAC_BITS;
      EASE_IN_OUT: begin
        if (a < (ONE >> 1)) return (2 * a * a) >> FRAC_BITS;
        return (((4 * ONE - 2 * a) * a) >> FRAC_BITS) - ONE;
      end
      default:  return a;
    endcase
  endfunction

  // floor of the weighted blend, also when the channel falls
  function automatic logic [15:0] blend_channel(logic [15:0] lo, logic [15:0] hi,
                                                longint unsigned e);
    if (hi >= lo) return 16'(lo + ((e * (hi - lo)) >> FRAC_BITS));
    return 16'(lo - ((e * (lo - hi) + ONE - 1) >> FRAC_BITS));
  endfunction

  function automatic lens_result_t predict_lens(req_t kind, logic [31:0] t, logic [15:0] f,
                                                logic [15:0] ir, logic [15:0] z, ease_t ez);
    lens_result_t r;
    int pos, a, last;
    longint unsigned span, alpha, e;
    r = '{16'd0, 16'd0, 16'd0, 1'b0, 7'd0};
    case (kind)
      REQ_CLEAR: tbl_count = 0;
      REQ_INSERT: begin
        if (tbl_count >= MAX_KEYS) r.status = 1'b1;
        else begin
          pos = 0;
          while (pos < tbl_count && tbl_time[pos] <= t) pos++;
          for (int i = tbl_count; i > pos; i--) begin
            tbl_time[i] = tbl_time[i-1]; tbl_focus[i] = tbl_focus[i-1];
            tbl_iris[i] = tbl_iris[i-1]; tbl_zoom[i] = tbl_zoom[i-1];
            tbl_ease[i] = tbl_ease[i-1];
          end
          tbl_time[pos] = t; tbl_focus[pos] = f; tbl_iris[pos] = ir;
          tbl_zoom[pos] = z; tbl_ease[pos] = ez;
          tbl_count++;
        end
      end
      REQ_QUERY: begin
        last = tbl_count - 1;
        if (tbl_count == 0) ;
        else if (tbl_count == 1 || t <= tbl_time[0]) begin
          r.focus = tbl_focus[0]; r.iris = tbl_iris[0]; r.zoom = tbl_zoom[0];
        end else if (t >= tbl_time[last]) begin
          r.focus = tbl_focus[last]; r.iris = tbl_iris[last]; r.zoom = tbl_zoom[last];
        end else begin
          a = 0;
          for (int i = 0; i < last; i++)
            if (tbl_time[i+1] > t) begin
              a = i;
              break;
            end
          span = longint'(tbl_time[a+1]) - longint'(tbl_time[a]);
          alpha = 0;
          if (span != 0 && t >= tbl_time[a])
            alpha = (longint'(t - tbl_time[a]) << FRAC_BITS) / span;
          e = eased_alpha(alpha, tbl_ease[a]);
          r.focus = blend_channel(tbl_focus[a], tbl_focus[a+1], e);
          r.iris  = blend_channel(tbl_iris[a], tbl_iris[a+1], e);
          r.zoom  = blend_channel(tbl_zoom[a], tbl_zoom[a+1], e);
        end
      end
      default: ;
    endcase
    r.count = tbl_count[6:0];
    return r;
  endfunction

  // keep valid high across back-to-back words; drop it only while idling
  task automatic send_word(req_t kind, logic [31:0] t, logic [15:0] f = 16'd0,
                           logic [15:0] ir = 16'd0, logic [15:0] z = 16'd0,
                           ease_t ez = EASE_LINEAR);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= kind; req.time_ticks <= t;
    req.kf_focus <= f; req.kf_iris <= ir; req.kf_zoom <= z; req.kf_easing <= ez;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(predict_lens(kind, t, f, ir, z, ez));
    words_sent++;
    if (kind == REQ_QUERY) queries_sent++;
  endtask

  task automatic insert_rand(logic [31:0] t);
    send_word(REQ_INSERT, t, 16'($urandom), 16'($urandom), 16'($urandom),
              ease_t'($urandom_range(3)));
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else begin
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response word at %0t", $time);
        end else begin
          lens_result_t x;
          x = pending_results.pop_front();
          if (rsp.status) rejects_seen++;
          if (rsp.focus_out !== x.focus || rsp.iris_out !== x.iris ||
              rsp.zoom_out !== x.zoom || rsp.status !== x.status ||
              rsp.count_out !== x.count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t: exp f=%h i=%h z=%h st=%b n=%0d",
                       $time, x.focus, x.iris, x.zoom, x.status, x.count);
              $display("  got f=%h i=%h z=%h st=%b n=%0d", rsp.focus_out,
                       rsp.iris_out, rsp.zoom_out, rsp.status, rsp.count_out);
            end
          end
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_edge_cases();
    send_word(REQ_QUERY, 32'd500);                        // empty table
    send_word(REQ_NONE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, EASE_IN_OUT);
    send_word(REQ_INSERT, 32'd1000, 16'h0000, 16'hFFFF, 16'h1234, EASE_LINEAR);
    send_word(REQ_QUERY, 32'd0);                          // single key
    send_word(REQ_QUERY, 32'hFFFF_FFFF);
    send_word(REQ_INSERT, 32'd2000, 16'hFFFF, 16'h0000, 16'h4321, EASE_IN);
    send_word(REQ_INSERT, 32'd1000, 16'h8000, 16'h7FFF, 16'h0001, EASE_OUT); // equal time
    send_word(REQ_INSERT, 32'd3000, 16'h0001, 16'hFFFE, 16'hAAAA, EASE_IN_OUT);
    send_word(REQ_INSERT, 32'hFFFF_FFFF, 16'h5555, 16'h0F0F, 16'hF0F0, EASE_LINEAR);
    send_word(REQ_INSERT, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, EASE_IN);
    send_word(REQ_QUERY, 32'd0);
    send_word(REQ_QUERY, 32'd1000);
    send_word(REQ_QUERY, 32'd1500);
    send_word(REQ_QUERY, 32'd2250);
    send_word(REQ_QUERY, 32'd2500);
    send_word(REQ_QUERY, 32'd2750);
    send_word(REQ_QUERY, 32'd2999);
    send_word(REQ_QUERY, 32'h8000_0000);
    send_word(REQ_QUERY, 32'hFFFF_FFFE);
    send_word(REQ_QUERY, 32'hFFFF_FFFF);
    send_word(REQ_CLEAR, 32'hFFFF_FFFF);
    send_word(REQ_QUERY, 32'd1000);
    drain();
  endtask

  task automatic test_full_table();
    send_word(REQ_CLEAR, 32'd0);
    for (int i = 0; i < MAX_KEYS; i++) insert_rand($urandom_range(0, 5000));
    insert_rand(32'd100);                                  // rejected
    insert_rand(32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_word(REQ_QUERY, $urandom_range(0, 5100));
    drain();
  endtask

  // scenes: clear, up to MAX_KEYS + 2 keys, then queries mostly aimed inside the key range, mixed with random words
  task automatic test_random_scenes(int n_words);
    int stop, nk;
    logic [31:0] base, t;
    longint unsigned span;
    stop = words_sent + n_words;
    while (words_sent < stop) begin
      send_word(REQ_CLEAR, $urandom);
      nk = ($urandom_range(9) == 0) ? $urandom_range(20, MAX_KEYS + 2) : $urandom_range(1, 8);
      base = ($urandom_range(1) == 0) ? $urandom : $urandom_range(0, 100);
      for (int i = 0; i < nk; i++)
        insert_rand(($urandom_range(3) == 0) ? $urandom : base + $urandom_range(0, 2000));
      for (int q = $urandom_range(2, 10); q > 0; q--) begin
        case ($urandom_range(9))
          0: send_word(REQ_QUERY, $urandom);
          1: send_word(req_t'($urandom_range(3)), $urandom, 16'($urandom), 16'($urandom),
                       16'($urandom), ease_t'($urandom_range(3)));
          2: insert_rand(base + $urandom_range(0, 2000));
          default: begin
            if (tbl_count >= 2) begin
              int k;
              k = $urandom_range(0, tbl_count - 2);
              span = longint'(tbl_time[k+1]) - longint'(tbl_time[k]);
              t = 32'(tbl_time[k] + ((span == 0) ? 0 : ({$urandom, $urandom} % span)));
            end else t = base + $urandom_range(0, 2000);
            send_word(REQ_QUERY, t);
          end
        endcase
      end
    end
    drain();
  endtask

  initial begin
    req.valid = 1'b0; req.req_type = REQ_NONE; req.time_ticks = '0;
    req.kf_focus = '0; req.kf_iris = '0; req.kf_zoom = '0; req.kf_easing = EASE_LINEAR;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edge_cases();
    test_full_table();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random_scenes(300);
    send_idle_pct = 68; recv_stall_pct = 0;  test_random_scenes(300);
    send_idle_pct = 0;  recv_stall_pct = 68; test_random_scenes(300);
    send_idle_pct = 34; recv_stall_pct = 34; test_random_scenes(300);
    $display("sent %0d words (%0d queries), checked %0d responses, %0d full-table rejects",
             words_sent, queries_sent, results_seen, rejects_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && pending_results.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("timeout with %0d responses outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
